// ----- hdl/tlvp_pkg.sv -----
// ----------------------------------------------------------------------------
// tlvp_pkg
// Shared types and constants for the TLV packet parser: payload structs,
// record kinds, status codes and sizing of the response queue.
// ----------------------------------------------------------------------------
package tlvp_pkg;

   // Sizing
   localparam int MAX_ENTRY_SLOTS  = 16;
   localparam int MAX_PACKET_BYTES = 250;
   localparam int HEADER_BYTES     = 2;
   localparam int POS_W            = 9;
   localparam int ENTRY_CNT_W      = $clog2(MAX_ENTRY_SLOTS + 1);

   // Response queue: room for two records pushed in one cycle
   localparam int RSP_Q_DEPTH = 4;
   localparam int RSP_Q_PTR_W = $clog2(RSP_Q_DEPTH);
   localparam int RSP_Q_CNT_W = $clog2(RSP_Q_DEPTH + 1);

   // Record kinds
   localparam logic KIND_ENTRY  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_TOO_SHORT = 2'd1;
   localparam logic [1:0] ST_BAD_LEN   = 2'd2;
   localparam logic [1:0] ST_OVERSIZE  = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] main_command;
      logic [7:0] entry_command;
      logic [7:0] entry_offset;
      logic [7:0] entry_length;
      logic [3:0] entry_index;
      logic [4:0] entry_total;
      logic [7:0] payload_length;
      logic [1:0] status;
      logic       truncated;
      logic       last_of_run;
   } rsp_type;

   // Records produced by one accepted byte
   typedef struct packed {
      logic    ent_valid;
      rsp_type ent;
      logic    sts_valid;
      rsp_type sts;
   } parse_out_type;

endpackage

// ----- hdl/tlvp_parse.sv -----
// ----------------------------------------------------------------------------
// tlvp_parse
// Byte-wise TLV parse state. On each accepted byte it updates the phase and
// counters and presents the entry and status records that byte produces.
// ----------------------------------------------------------------------------
module tlvp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  tlvp_pkg::req_type      req_data,
   output tlvp_pkg::parse_out_type result
);

   localparam logic [2:0] PH_MAIN = 3'd0;
   localparam logic [2:0] PH_LEN  = 3'd1;
   localparam logic [2:0] PH_ECMD = 3'd2;
   localparam logic [2:0] PH_ELEN = 3'd3;
   localparam logic [2:0] PH_DATA = 3'd4;
   localparam logic [2:0] PH_IDLE = 3'd5;

   localparam logic [tlvp_pkg::POS_W-1:0] POS_MAX = '1;

   logic [2:0]                       phase_ff, phase_in;
   logic [tlvp_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [7:0]                       main_ff, main_in;
   logic [7:0]                       decl_ff, decl_in;
   logic [7:0]                       estart_ff, estart_in;
   logic [7:0]                       ecode_ff, ecode_in;
   logic [7:0]                       pleft_ff, pleft_in;
   logic [7:0]                       dleft_ff, dleft_in;
   logic [tlvp_pkg::ENTRY_CNT_W-1:0] found_ff, found_in;
   logic                             cut_ff, cut_in;
   logic                             long_ff, long_in;

   logic [7:0]  b;
   logic [7:0]  pleft_dec;
   logic [7:0]  dleft_dec;
   logic [31:0] idx32;
   logic [31:0] tot32;
   logic [1:0]  st;
   logic        ent_valid;

   assign b         = req_data.data_byte;
   assign pleft_dec = pleft_ff - 8'd1;
   assign dleft_dec = dleft_ff - 8'd1;

   // Phase and counter update for the current byte
   always_comb begin
      phase_in  = phase_ff;
      main_in   = main_ff;
      decl_in   = decl_ff;
      estart_in = estart_ff;
      ecode_in  = ecode_ff;
      pleft_in  = pleft_ff;
      dleft_in  = dleft_ff;
      found_in  = found_ff;
      cut_in    = cut_ff;
      ent_valid = 1'b0;
      long_in   = long_ff |
                  (10'(pos_ff) >= 10'(tlvp_pkg::MAX_PACKET_BYTES));
      pos_in    = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;

      unique case (phase_ff)
         PH_MAIN: begin
            main_in  = b;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            decl_in  = b;
            pleft_in = b;
            phase_in = (b >= 8'(tlvp_pkg::HEADER_BYTES)) ? PH_ECMD : PH_IDLE;
         end
         PH_ECMD: begin
            ecode_in  = b;
            estart_in = pos_ff[7:0];
            pleft_in  = pleft_dec;
            phase_in  = PH_ELEN;
         end
         PH_ELEN: begin
            pleft_in = pleft_dec;
            if (b > pleft_dec) begin
               cut_in   = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               if (found_ff < tlvp_pkg::ENTRY_CNT_W'(tlvp_pkg::MAX_ENTRY_SLOTS)) begin
                  ent_valid = 1'b1;
                  found_in  = found_ff + 1'b1;
               end
               dleft_in = b;
               if (b == 8'd0) begin
                  phase_in = (pleft_dec >= 8'(tlvp_pkg::HEADER_BYTES)) ?
                             PH_ECMD : PH_IDLE;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            dleft_in = dleft_dec;
            pleft_in = pleft_dec;
            if (dleft_dec == 8'd0) begin
               phase_in = (pleft_dec >= 8'(tlvp_pkg::HEADER_BYTES)) ?
                          PH_ECMD : PH_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   // End-of-packet status
   always_comb begin
      if (pos_ff == '0) begin
         st = tlvp_pkg::ST_TOO_SHORT;
      end else if (10'(decl_in) > (10'(pos_ff) - 10'd1)) begin
         st = tlvp_pkg::ST_BAD_LEN;
      end else if (long_in) begin
         st = tlvp_pkg::ST_OVERSIZE;
      end else begin
         st = tlvp_pkg::ST_OK;
      end
   end

   assign idx32 = 32'(found_ff);
   assign tot32 = 32'(found_in);

   // Record assembly
   always_comb begin
      result.ent_valid            = ent_valid;
      result.ent.kind             = tlvp_pkg::KIND_ENTRY;
      result.ent.main_command     = main_in;
      result.ent.entry_command    = ecode_ff;
      result.ent.entry_offset     = estart_ff;
      result.ent.entry_length     = b;
      result.ent.entry_index      = idx32[3:0];
      result.ent.entry_total      = 5'd0;
      result.ent.payload_length   = decl_in;
      result.ent.status           = tlvp_pkg::ST_OK;
      result.ent.truncated        = 1'b0;
      result.ent.last_of_run      = ~req_data.last_byte;

      result.sts_valid            = req_data.last_byte;
      result.sts.kind             = tlvp_pkg::KIND_STATUS;
      result.sts.main_command     = main_in;
      result.sts.entry_command    = 8'd0;
      result.sts.entry_offset     = 8'd0;
      result.sts.entry_length     = 8'd0;
      result.sts.entry_index      = 4'd0;
      result.sts.entry_total      = (st == tlvp_pkg::ST_OK) ? tot32[4:0] : 5'd0;
      result.sts.payload_length   = decl_in;
      result.sts.status           = st;
      result.sts.truncated        = (st == tlvp_pkg::ST_OK) ? cut_in : 1'b0;
      result.sts.last_of_run      = 1'b1;
   end

   // State registers; the final byte returns everything to reset values
   always_ff @(posedge clock) begin
      if (reset || (fire && req_data.last_byte)) begin
         phase_ff  <= PH_MAIN;
         pos_ff    <= '0;
         main_ff   <= '0;
         decl_ff   <= '0;
         estart_ff <= '0;
         ecode_ff  <= '0;
         pleft_ff  <= '0;
         dleft_ff  <= '0;
         found_ff  <= '0;
         cut_ff    <= 1'b0;
         long_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         main_ff   <= main_in;
         decl_ff   <= decl_in;
         estart_ff <= estart_in;
         ecode_ff  <= ecode_in;
         pleft_ff  <= pleft_in;
         dleft_ff  <= dleft_in;
         found_ff  <= found_in;
         cut_ff    <= cut_in;
         long_ff   <= long_in;
      end
   end

endmodule

// ----- hdl/tlvp_rsp_queue.sv -----
// ----------------------------------------------------------------------------
// tlvp_rsp_queue
// Small register queue for result records. Takes up to two records per
// cycle and delivers one per transfer on the response channel.
// ----------------------------------------------------------------------------
module tlvp_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tlvp_pkg::parse_out_type records,
   output logic                    space_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tlvp_pkg::rsp_type       rsp_data
);

   tlvp_pkg::rsp_type slots_ff [tlvp_pkg::RSP_Q_DEPTH];

   logic [tlvp_pkg::RSP_Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tlvp_pkg::RSP_Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tlvp_pkg::RSP_Q_CNT_W-1:0] count_ff, count_in;
   logic [tlvp_pkg::RSP_Q_PTR_W-1:0] sts_ptr;
   logic                             push_ent;
   logic                             push_sts;
   logic                             pop;

   assign push_ent  = push & records.ent_valid;
   assign push_sts  = push & records.sts_valid;
   assign pop       = rsp_valid & rsp_ready;
   assign sts_ptr   = wr_ptr_ff + tlvp_pkg::RSP_Q_PTR_W'(push_ent);

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slots_ff[rd_ptr_ff];
   assign space_ok  = (count_ff <= tlvp_pkg::RSP_Q_CNT_W'(tlvp_pkg::RSP_Q_DEPTH - 2));

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + tlvp_pkg::RSP_Q_PTR_W'(push_ent) +
                  tlvp_pkg::RSP_Q_PTR_W'(push_sts);
      rd_ptr_in = rd_ptr_ff + tlvp_pkg::RSP_Q_PTR_W'(pop);
      count_in  = count_ff + tlvp_pkg::RSP_Q_CNT_W'(push_ent) +
                  tlvp_pkg::RSP_Q_CNT_W'(push_sts) - tlvp_pkg::RSP_Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage, entry record first when a byte gives two
   always_ff @(posedge clock) begin
      if (push_ent) begin
         slots_ff[wr_ptr_ff] <= records.ent;
      end
      if (push_sts) begin
         slots_ff[sts_ptr] <= records.sts;
      end
   end

endmodule

// ----- hdl/tlv_packet_parser_core.sv -----
// ----------------------------------------------------------------------------
// tlv_packet_parser_core
// Records are queued as their byte transfers. Throughput: one byte per cycle
// while the queue has room; a final byte that completes an entry gives two
// records, drained one per cycle (rsp_ready high) by the four-entry queue.
// Reset: synchronous, active high; clears parse state and empties the queue.
// The parse state also returns to its reset values after every final byte.
// ----------------------------------------------------------------------------
module tlv_packet_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlvp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlvp_pkg::rsp_type rsp_data
);

   tlvp_pkg::parse_out_type records;
   logic                    fire;
   logic                    space_ok;

   assign req_ready = space_ok;
   assign fire      = req_valid & req_ready;

   // Per-byte parse state and record build
   tlvp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_data (req_data),
      .result   (records)
   );

   // Result buffering toward the response channel
   tlvp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .records   (records),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
